// File: rtl/core/swr_pkg.sv
// Shared types, constants and codes for the sliding window receiver.
package swr_pkg;

	localparam int SEQ_W            = 32;
	localparam int LEN_W            = 12;
	localparam int HND_W            = 16;
	localparam int WIN_W            = 6;
	localparam int WINDOW_SLOTS_DEF = 32;
	localparam int MAX_PAYLOAD      = 1461;
	localparam int DRAIN_LIMIT      = 31;
	localparam int DRN_W            = $clog2(DRAIN_LIMIT + 1);
	localparam int REM_CNT_W        = $clog2(SEQ_W);
	localparam int CFG_IDX_W        = 1;

	localparam logic [WIN_W-1:0]     WIN_RESET       = WIN_W'(32);
	localparam logic [CFG_IDX_W-1:0] CFG_WIN         = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_MODE    = CFG_IDX_W'(1);
	localparam logic                 RK_ACK          = 1'b0;
	localparam logic                 RK_DELIVER      = 1'b1;
	localparam logic                 AM_CUMULATIVE   = 1'b0;

	typedef enum logic [1:0] {
		PKT_START = 2'd0,
		PKT_END   = 2'd1,
		PKT_DATA  = 2'd2,
		PKT_ACK   = 2'd3
	} pkt_type_t;

	typedef enum logic [1:0] {
		PH_WAIT   = 2'd0,
		PH_RECV   = 2'd1,
		PH_CLOSED = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		RS_NONE         = 3'd0,
		RS_START_ACK    = 3'd1,
		RS_END_ACK      = 3'd2,
		RS_DELIVER_IN   = 3'd3,
		RS_DELIVER_SLOT = 3'd4,
		RS_ACK_NEXT     = 3'd5,
		RS_ACK_SEQ      = 3'd6
	} res_src_t;

	typedef enum logic [2:0] {
		ST_IDLE      = 3'd0,
		ST_REMAIN    = 3'd1,
		ST_EVAL      = 3'd2,
		ST_STORE     = 3'd3,
		ST_DRAIN_CHK = 3'd4,
		ST_DRAIN_RD  = 3'd5,
		ST_ACK       = 3'd6,
		ST_FLUSH     = 3'd7
	} state_t;

	typedef struct packed {
		logic [1:0]       packet_type;
		logic [SEQ_W-1:0] seq_num;
		logic [LEN_W-1:0] payload_length;
		logic             checksum_ok;
		logic [HND_W-1:0] payload_handle;
	} swr_in_t;

	typedef struct packed {
		logic             result_kind;
		logic [SEQ_W-1:0] result_seq;
		logic [LEN_W-1:0] result_length;
		logic [HND_W-1:0] result_handle;
		logic             session_closed;
		logic             last_result;
	} swr_out_t;

	typedef struct packed {
		logic     capture;
		logic     rem_start;
		logic     rem_step;
		logic     push;
		res_src_t src;
		logic     start_session;
		logic     close_session;
		logic     advance;
		logic     drain_reset;
		logic     slot_read;
		logic     drain_take;
		logic     store;
		logic     flush;
	} swr_cmd_t;

	typedef struct packed {
		logic      pkt_ok;
		pkt_type_t ptype;
		phase_t    phase;
		logic      seq_eq_ne;
		logic      in_win;
		logic      idx_ok;
		logic      rem_last;
		logic      slot_hit;
		logic      ack_go;
		logic      ack_mode;
		logic      can_push;
		logic      hold_v;
		logic      out_free;
	} swr_status_t;

endpackage

// File: rtl/core/swr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module swr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/swr_datapath.sv
// Datapath: item capture, window state, slot store, remainder unit and result staging.
module swr_datapath #(
	parameter int WINDOW_SLOTS = swr_pkg::WINDOW_SLOTS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  swr_pkg::swr_in_t                   pkt,
	input  logic                               res_stall,
	output logic                               res_valid,
	output swr_pkg::swr_out_t                  res,
	input  logic                               cfg_we,
	input  logic [swr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swr_pkg::WIN_W-1:0]          cfg_data,
	input  swr_pkg::swr_cmd_t                  cmd,
	output swr_pkg::swr_status_t               st
);

	import swr_pkg::*;

	localparam int IW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam int SW = LEN_W + HND_W;
	localparam logic [WIN_W-1:0] SLOTS_W = WIN_W'(WINDOW_SLOTS);

	swr_in_t                item_q;
	logic [WIN_W-1:0]       win_q;
	logic                   mode_q;
	phase_t                 phase_q;
	logic [SEQ_W-1:0]       ne_q;
	logic [IW-1:0]          idx_q;
	logic                   idx_ok_q;
	logic [WIN_W-1:0]       rem_q;
	logic [SEQ_W-1:0]       rsh_q;
	logic [REM_CNT_W-1:0]   rcnt_q;
	logic [DRN_W-1:0]       drained_q;
	logic [WINDOW_SLOTS-1:0] valid_q;
	swr_out_t               hold_q;
	logic                   hold_v_q;
	swr_out_t               out_q;
	logic                   out_v_q;

	logic [WIN_W-1:0]  w;
	logic [SEQ_W:0]    top;
	logic [WIN_W:0]    rem_t;
	logic [WIN_W:0]    rem_diff;
	logic [WIN_W-1:0]  rem_nx;
	logic [WIN_W:0]    idx_ext;
	logic [WIN_W:0]    idx_p1;
	logic [IW-1:0]     idx_nx;
	logic [WIN_W-1:0]  off;
	logic [WIN_W:0]    sidx_sum;
	logic [WIN_W:0]    sidx_red;
	logic [IW-1:0]     sidx;
	logic [SW-1:0]     slot_rd;
	logic              out_free;
	logic              do_store;
	swr_out_t          res_new;
	swr_out_t          last_res;

	// Effective window: zero acts as one, oversize clamps to the slot count.
	always_comb begin
		if (win_q == '0) begin
			w = WIN_W'(1);
		end else if (win_q > SLOTS_W) begin
			w = SLOTS_W;
		end else begin
			w = win_q;
		end
	end

	assign top = {1'b0, ne_q} + (SEQ_W + 1)'(w) - (SEQ_W + 1)'(1);

	// One bit of next_expected mod window per cycle.
	assign rem_t    = {rem_q, rsh_q[SEQ_W-1]};
	assign rem_diff = rem_t - {1'b0, w};
	assign rem_nx   = (rem_t >= {1'b0, w}) ? rem_diff[WIN_W-1:0] : rem_t[WIN_W-1:0];

	assign idx_ext = (WIN_W + 1)'(idx_q);
	assign idx_p1  = idx_ext + (WIN_W + 1)'(1);
	// next_expected wrapping to zero restarts the slot index at zero
	assign idx_nx  = (idx_p1 == {1'b0, w} || ne_q == '1) ? '0 : idx_p1[IW-1:0];

	// Slot of an in-window packet: offset from next_expected, folded once.
	assign off      = item_q.seq_num[WIN_W-1:0] - ne_q[WIN_W-1:0];
	assign sidx_sum = idx_ext + (WIN_W + 1)'(off);
	assign sidx_red = (sidx_sum >= {1'b0, w}) ? (sidx_sum - {1'b0, w}) : sidx_sum;
	assign sidx     = sidx_red[IW-1:0];
	assign do_store = cmd.store && !valid_q[sidx];

	swr_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW_SLOTS)
	) u_slots (
		.clk     (clk),
		.wr_en   (do_store),
		.wr_addr (sidx),
		.wr_data ({item_q.payload_length, item_q.payload_handle}),
		.rd_en   (cmd.slot_read),
		.rd_addr (idx_q),
		.rd_data (slot_rd)
	);

	always_comb begin
		res_new = '0;
		case (cmd.src)
			RS_START_ACK: begin
				res_new.result_kind = RK_ACK;
				res_new.result_seq  = item_q.seq_num;
			end
			RS_END_ACK: begin
				res_new.result_kind    = RK_ACK;
				res_new.result_seq     = ne_q;
				res_new.session_closed = 1'b1;
			end
			RS_DELIVER_IN: begin
				res_new.result_kind   = RK_DELIVER;
				res_new.result_seq    = item_q.seq_num;
				res_new.result_length = item_q.payload_length;
				res_new.result_handle = item_q.payload_handle;
			end
			RS_DELIVER_SLOT: begin
				res_new.result_kind   = RK_DELIVER;
				res_new.result_seq    = ne_q;
				res_new.result_length = slot_rd[SW-1:HND_W];
				res_new.result_handle = slot_rd[HND_W-1:0];
			end
			RS_ACK_NEXT: begin
				res_new.result_kind = RK_ACK;
				res_new.result_seq  = ne_q;
			end
			RS_ACK_SEQ: begin
				res_new.result_kind = RK_ACK;
				res_new.result_seq  = item_q.seq_num;
			end
			default: res_new = '0;
		endcase
	end

	always_comb begin
		last_res             = hold_q;
		last_res.last_result = 1'b1;
	end

	assign out_free = !out_v_q || !res_stall;

	always_comb begin
		st.pkt_ok    = item_q.checksum_ok &&
		               !(pkt_type_t'(item_q.packet_type) == PKT_DATA &&
		                 item_q.payload_length > LEN_W'(MAX_PAYLOAD));
		st.ptype     = pkt_type_t'(item_q.packet_type);
		st.phase     = phase_q;
		st.seq_eq_ne = item_q.seq_num == ne_q;
		st.in_win    = (item_q.seq_num > ne_q) && ({1'b0, item_q.seq_num} <= top);
		st.idx_ok    = idx_ok_q;
		st.rem_last  = rcnt_q == REM_CNT_W'(SEQ_W - 1);
		st.slot_hit  = valid_q[idx_q] && (drained_q < DRN_W'(DRAIN_LIMIT));
		st.ack_go    = (mode_q == AM_CUMULATIVE) || ({1'b0, item_q.seq_num} <= top);
		st.ack_mode  = mode_q;
		st.can_push  = !hold_v_q || out_free;
		st.hold_v    = hold_v_q;
		st.out_free  = out_free;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= WIN_RESET;
			mode_q    <= AM_CUMULATIVE;
			phase_q   <= PH_WAIT;
			ne_q      <= '0;
			idx_q     <= '0;
			idx_ok_q  <= 1'b1;
			rcnt_q    <= '0;
			drained_q <= '0;
			valid_q   <= '0;
			hold_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIN: begin
						win_q    <= cfg_data;
						idx_ok_q <= 1'b0;
					end
					CFG_ACK_MODE: mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.rem_start) begin
				rcnt_q <= '0;
			end
			if (cmd.rem_step) begin
				rcnt_q <= rcnt_q + REM_CNT_W'(1);
				if (st.rem_last) begin
					idx_q    <= rem_nx[IW-1:0];
					idx_ok_q <= 1'b1;
				end
			end
			if (cmd.start_session) begin
				phase_q  <= PH_RECV;
				ne_q     <= '0;
				idx_q    <= '0;
				idx_ok_q <= 1'b1;
				valid_q  <= '0;
			end
			if (cmd.close_session) begin
				phase_q <= PH_CLOSED;
			end
			if (cmd.advance) begin
				ne_q  <= ne_q + SEQ_W'(1);
				idx_q <= idx_nx;
			end
			if (cmd.drain_reset) begin
				drained_q <= '0;
			end
			if (cmd.drain_take) begin
				drained_q      <= drained_q + DRN_W'(1);
				valid_q[idx_q] <= 1'b0;
			end
			if (do_store) begin
				valid_q[sidx] <= 1'b1;
			end
			if (cmd.push) begin
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
			if (cmd.flush || (cmd.push && hold_v_q)) begin
				out_v_q <= 1'b1;
			end else if (!res_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= pkt;
		end
		if (cmd.rem_start) begin
			rem_q <= '0;
			rsh_q <= ne_q;
		end
		if (cmd.rem_step) begin
			rem_q <= rem_nx;
			rsh_q <= {rsh_q[SEQ_W-2:0], 1'b0};
		end
		if (cmd.push) begin
			hold_q <= res_new;
		end
		if (cmd.flush) begin
			out_q <= last_res;
		end else if (cmd.push && hold_v_q) begin
			out_q <= hold_q;
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

endmodule

// File: rtl/core/swr_ctrl.sv
// Controller state machine: sequences each packet through remainder, evaluate, store, drain, ack and flush.
module swr_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pkt_valid,
	output logic                  pkt_stall,
	input  swr_pkg::swr_status_t  st,
	output swr_pkg::swr_cmd_t     cmd
);

	import swr_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign pkt_stall = state_q != ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (pkt_valid) begin
					cmd.capture = 1'b1;
					if (st.idx_ok) begin
						state_d = ST_EVAL;
					end else begin
						cmd.rem_start = 1'b1;
						state_d       = ST_REMAIN;
					end
				end
			end
			ST_REMAIN: begin
				cmd.rem_step = 1'b1;
				if (st.rem_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_IDLE;
				if (st.pkt_ok) begin
					unique case (st.phase)
						PH_WAIT: begin
							if (st.ptype == PKT_START) begin
								cmd.push          = 1'b1;
								cmd.src           = RS_START_ACK;
								cmd.start_session = 1'b1;
								state_d           = ST_FLUSH;
							end
						end
						PH_RECV: begin
							if (st.ptype == PKT_END) begin
								if (st.seq_eq_ne) begin
									cmd.push          = 1'b1;
									cmd.src           = RS_END_ACK;
									cmd.close_session = 1'b1;
									state_d           = ST_FLUSH;
								end
							end else if (st.ptype == PKT_DATA) begin
								if (st.seq_eq_ne) begin
									cmd.push        = 1'b1;
									cmd.src         = RS_DELIVER_IN;
									cmd.advance     = 1'b1;
									cmd.drain_reset = 1'b1;
									state_d         = ST_DRAIN_CHK;
								end else if (st.in_win) begin
									state_d = ST_STORE;
								end else begin
									state_d = ST_ACK;
								end
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = ST_ACK;
			end
			ST_DRAIN_CHK: begin
				if (st.slot_hit) begin
					cmd.slot_read = 1'b1;
					state_d       = ST_DRAIN_RD;
				end else begin
					state_d = ST_ACK;
				end
			end
			ST_DRAIN_RD: begin
				// hold the read data until the staging register can take it
				if (st.can_push) begin
					cmd.push       = 1'b1;
					cmd.src        = RS_DELIVER_SLOT;
					cmd.advance    = 1'b1;
					cmd.drain_take = 1'b1;
					state_d        = ST_DRAIN_CHK;
				end
			end
			ST_ACK: begin
				if (!st.ack_go) begin
					state_d = ST_FLUSH;
				end else if (st.can_push) begin
					cmd.push = 1'b1;
					cmd.src  = (st.ack_mode == AM_CUMULATIVE) ? RS_ACK_NEXT : RS_ACK_SEQ;
					state_d  = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// release the staged result marked as the last of this packet
				if (!st.hold_v) begin
					state_d = ST_IDLE;
				end else if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/core/sliding_window_receiver.sv
// Selective-repeat sliding window receiver: top level joining controller and datapath.
// Flow: each packet is captured and evaluated, and may be acked; data is delivered in
//   order, stored or dropped, and in-order delivery drains up to 31 buffered slots
//   via the one-read-per-cycle slot RAM and its registered read, each held on a stall.
// The first packet after a window register write first runs the serial slot-index
//   remainder. One packet is in work at a time; the last result waits in the output register.
// Reset: phase waits for start, next expected is 0, all slot valid bits clear at once.
module sliding_window_receiver #(
	parameter int WINDOW_SLOTS = swr_pkg::WINDOW_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pkt_valid,
	output logic                           pkt_stall,
	input  swr_pkg::swr_in_t               pkt,
	output logic                           res_valid,
	input  logic                           res_stall,
	output swr_pkg::swr_out_t              res,
	input  logic                           cfg_we,
	input  logic [swr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swr_pkg::WIN_W-1:0]      cfg_data
);

	import swr_pkg::*;

	swr_cmd_t    cmd;
	swr_status_t st;

	swr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.st        (st),
		.cmd       (cmd)
	);

	swr_datapath #(
		.WINDOW_SLOTS (WINDOW_SLOTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.st        (st)
	);

endmodule
